// ----- rtl/core/rational_arith_unit_macros.svh -----
// Assertion macros shared by the rational arithmetic unit.
`ifndef RATIONAL_ARITH_UNIT_MACROS_SVH
`define RATIONAL_ARITH_UNIT_MACROS_SVH
// Check that a condition implies a property in the same cycle, outside reset.
`define RAU_ASSERT_IMP(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");
// Check that a condition implies a property in the next cycle, outside reset.
`define RAU_ASSERT_NXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");
`endif

// ----- rtl/core/rau_pkg.sv -----
// Package with opcodes, widths and controller types of the rational arithmetic unit.
package rau_pkg;
  localparam int unsigned OperandWidthDef = 16;
  localparam int unsigned OpWidth = 4;

  localparam logic [OpWidth-1:0] OP_ADD = 4'd0;
  localparam logic [OpWidth-1:0] OP_SUB = 4'd1;
  localparam logic [OpWidth-1:0] OP_MUL = 4'd2;
  localparam logic [OpWidth-1:0] OP_DIV = 4'd3;
  localparam logic [OpWidth-1:0] OP_EQ  = 4'd4;
  localparam logic [OpWidth-1:0] OP_NE  = 4'd5;
  localparam logic [OpWidth-1:0] OP_GE  = 4'd6;
  localparam logic [OpWidth-1:0] OP_GT  = 4'd7;
  localparam logic [OpWidth-1:0] OP_LE  = 4'd8;
  localparam logic [OpWidth-1:0] OP_LT  = 4'd9;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MUL   = 8'b0000_0010,
    ST_FORM  = 8'b0000_0100,
    ST_GCD   = 8'b0000_1000,
    ST_DIVN  = 8'b0001_0000,
    ST_DIVD  = 8'b0010_0000,
    ST_FIN   = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;
    logic mul;
    logic form;
    logic gcd_start;
    logic gcd_step;
    logic div_start;
    logic div_step;
    logic div_num;
    logic fin;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic arith;
    logic gcd_done;
    logic div_done;
  } sts_t;
endpackage

// ----- rtl/core/rau_datapath.sv -----
// Datapath: operand normalize, cross products, binary gcd and restoring divider.
module rau_datapath #(
  parameter int unsigned OPERAND_WIDTH = rau_pkg::OperandWidthDef
) (
  input  logic                             clk,
  input  rau_pkg::cmd_t                    cmd,
  output rau_pkg::sts_t                    sts,
  input  logic [rau_pkg::OpWidth-1:0]      in_opcode,
  input  logic signed [OPERAND_WIDTH-1:0]  in_a_num,
  input  logic signed [OPERAND_WIDTH-1:0]  in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0]  in_b_num,
  input  logic signed [OPERAND_WIDTH-1:0]  in_b_den,
  output logic signed [2*OPERAND_WIDTH:0]  res_num,
  output logic [2*OPERAND_WIDTH-2:0]       res_den,
  output logic                             truth,
  output logic                             status
);
  localparam int unsigned W  = OPERAND_WIDTH + 1;   // normalized operand
  localparam int unsigned P  = 2 * W;               // product width
  localparam int unsigned M  = 2 * OPERAND_WIDTH + 1; // magnitude width
  localparam int unsigned CW = $clog2(M + 1);

  logic [rau_pkg::OpWidth-1:0] op_r;
  logic signed [W-1:0] an_r, ad_r, bn_r, bd_r;
  logic signed [P-1:0] p0_r, p1_r, p2_r, p3_r;
  logic [M-1:0] mag_r, den_r, u_r, v_r, g_r;
  logic [CW-1:0] sh_r, cnt_r;
  logic neg_r, arith_r, truth_r, status_r;
  logic [M-1:0] q_r, rem_r, dvd_r;

  // Normalize denominator signs on load.
  logic signed [W-1:0] an_x, ad_x, bn_x, bd_x;
  always_comb begin
    an_x = W'(in_a_num); ad_x = W'(in_a_den);
    bn_x = W'(in_b_num); bd_x = W'(in_b_den);
    if (ad_x < 0) begin an_x = -an_x; ad_x = -ad_x; end
    if (bd_x < 0) begin bn_x = -bn_x; bd_x = -bd_x; end
  end

  // Form results from cross products.
  logic signed [P:0] n_x, d_x;
  logic lt_x, eq_x, t_x, zden, zdiv, ar_x;
  always_comb begin
    zden = (in_a_den == '0) || (in_b_den == '0);
    zdiv = 1'b0;
    n_x = '0; d_x = (P+1)'(p3_r); ar_x = 1'b0; t_x = 1'b0;
    lt_x = p0_r < p1_r; eq_x = p0_r == p1_r;
    case (op_r)
      rau_pkg::OP_ADD: begin n_x = (P+1)'(p0_r) + (P+1)'(p1_r); ar_x = 1'b1; end
      rau_pkg::OP_SUB: begin n_x = (P+1)'(p0_r) - (P+1)'(p1_r); ar_x = 1'b1; end
      rau_pkg::OP_MUL: begin n_x = (P+1)'(p2_r); ar_x = 1'b1; end
      rau_pkg::OP_DIV: begin
        zdiv = bn_r == '0;
        n_x = (P+1)'(p0_r); d_x = (P+1)'(p1_r);
        if (d_x < 0) begin n_x = -n_x; d_x = -d_x; end
        ar_x = !zdiv;
      end
      rau_pkg::OP_EQ: t_x = eq_x;
      rau_pkg::OP_NE: t_x = !eq_x;
      rau_pkg::OP_GE: t_x = !lt_x;
      rau_pkg::OP_GT: t_x = !lt_x && !eq_x;
      rau_pkg::OP_LE: t_x = lt_x || eq_x;
      rau_pkg::OP_LT: t_x = lt_x;
      default: ;
    endcase
  end

  // Binary gcd step.
  logic [M-1:0] u_n, v_n;
  logic [CW-1:0] sh_n;
  logic gdone;
  always_comb begin
    u_n = u_r; v_n = v_r; sh_n = sh_r;
    gdone = (u_r == '0) || (v_r == '0) || (u_r == v_r);
    if (!gdone) begin
      if (!u_r[0] && !v_r[0]) begin u_n = u_r >> 1; v_n = v_r >> 1; sh_n = sh_r + 1'b1; end
      else if (!u_r[0]) u_n = u_r >> 1;
      else if (!v_r[0]) v_n = v_r >> 1;
      else if (u_r > v_r) u_n = (u_r - v_r) >> 1;
      else v_n = (v_r - u_r) >> 1;
    end
  end
  logic [M-1:0] gval;
  assign gval = ((u_r == '0) ? v_r : u_r) << sh_r;

  // Restoring division step by g.
  logic [M:0] trial;
  assign trial = {rem_r, dvd_r[M-1]} - {1'b0, g_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_opcode; an_r <= an_x; ad_r <= ad_x; bn_r <= bn_x; bd_r <= bd_x;
      status_r <= zden; arith_r <= 1'b0; truth_r <= 1'b0;
      mag_r <= '0; den_r <= M'(1);
    end
    if (cmd.mul) begin
      p0_r <= an_r * bd_r; p1_r <= bn_r * ad_r;
      p2_r <= an_r * bn_r;
      p3_r <= (op_r == rau_pkg::OP_DIV) ? ad_r * bn_r : ad_r * bd_r;
      if (op_r == rau_pkg::OP_DIV) p1_r <= ad_r * bn_r;
    end
    if (cmd.form && !status_r) begin
      arith_r <= ar_x; truth_r <= t_x; status_r <= zdiv;
      neg_r <= n_x < 0;
      if (ar_x) begin
        mag_r <= M'(n_x < 0 ? -n_x : n_x); den_r <= M'(d_x);
      end
    end
    if (cmd.gcd_start) begin u_r <= mag_r; v_r <= den_r; sh_r <= '0; end
    if (cmd.gcd_step) begin u_r <= u_n; v_r <= v_n; sh_r <= sh_n; end
    // a start issued as the denominator finishes loads the numerator
    if (cmd.div_start) begin
      if (!cmd.div_num) g_r <= gval;
      dvd_r <= (cmd.div_num || cmd.fin) ? mag_r : den_r;
      rem_r <= '0; q_r <= '0; cnt_r <= '0;
    end
    if (cmd.div_step) begin
      dvd_r <= dvd_r << 1; cnt_r <= cnt_r + 1'b1;
      if (!trial[M]) begin rem_r <= trial[M-1:0]; q_r <= {q_r[M-2:0], 1'b1}; end
      else begin rem_r <= {rem_r[M-2:0], dvd_r[M-1]}; q_r <= {q_r[M-2:0], 1'b0}; end
    end
    if (cmd.fin) begin
      if (cmd.div_num) mag_r <= q_r; else den_r <= q_r;
    end
  end

  assign sts.arith = arith_r && !status_r;
  assign sts.gcd_done = gdone;
  assign sts.div_done = cnt_r == CW'(M);

  assign res_num = (sts.arith && mag_r != '0) ? (neg_r ? -$signed(mag_r) : $signed(mag_r))
                                             : '0;
  assign res_den = (sts.arith && mag_r != '0) ? den_r[2*OPERAND_WIDTH-2:0]
                                             : (2*OPERAND_WIDTH-1)'(1);
  assign truth  = truth_r && !status_r;
  assign status = status_r;
endmodule

// ----- rtl/core/rau_ctrl.sv -----
// Controller state machine sequencing one item through the datapath.
module rau_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  rau_pkg::sts_t  sts,
  output rau_pkg::cmd_t  cmd
);
  rau_pkg::state_t state_r, state_nxt;
  logic num_r, num_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r; num_nxt = num_r; cmd = '0;
    cmd.div_num = num_r;
    case (state_r)
      rau_pkg::ST_IDLE: if (in_valid) begin cmd.load = 1'b1; state_nxt = rau_pkg::ST_MUL; end
      rau_pkg::ST_MUL: begin cmd.mul = 1'b1; state_nxt = rau_pkg::ST_FORM; end
      rau_pkg::ST_FORM: begin cmd.form = 1'b1; state_nxt = rau_pkg::ST_FIN; end
      rau_pkg::ST_FIN: begin
        if (sts.arith) begin cmd.gcd_start = 1'b1; state_nxt = rau_pkg::ST_GCD; end
        else state_nxt = rau_pkg::ST_OUT;
      end
      rau_pkg::ST_GCD: begin
        if (sts.gcd_done) begin
          cmd.div_start = 1'b1; cmd.div_num = 1'b0; num_nxt = 1'b0;
          state_nxt = rau_pkg::ST_DIVD;
        end else cmd.gcd_step = 1'b1;
      end
      rau_pkg::ST_DIVD: begin
        if (sts.div_done) begin
          cmd.fin = 1'b1; cmd.div_start = 1'b1; cmd.div_num = 1'b0;
          num_nxt = 1'b1; state_nxt = rau_pkg::ST_DIVN;
        end else cmd.div_step = 1'b1;
      end
      rau_pkg::ST_DIVN: begin
        if (sts.div_done) begin cmd.fin = 1'b1; state_nxt = rau_pkg::ST_OUT; end
        else cmd.div_step = 1'b1;
      end
      rau_pkg::ST_OUT: if (out_ready) state_nxt = rau_pkg::ST_IDLE;
      default: state_nxt = rau_pkg::ST_IDLE;
    endcase
  end

  // State and numerator-flag registers, cleared by synchronous reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rau_pkg::ST_IDLE; num_r <= 1'b0;
    end else begin
      state_r <= state_nxt; num_r <= num_nxt;
    end
  end

  assign in_ready  = state_r == rau_pkg::ST_IDLE;
  assign out_valid = state_r == rau_pkg::ST_OUT;
endmodule

// ----- rtl/core/rational_arith_unit.sv -----
// Rational arithmetic unit: one item in flight; after acceptance an item passes
// through the multiply and form steps and then, for add/sub/mul/div, the binary
// gcd loop and two bit-serial divisions by the gcd (denominator, then numerator);
// comparisons and errors skip the gcd loop and the divisions.
// The result is held on the out_ ports until taken; the next item is accepted
// once the result has been delivered.
`include "rational_arith_unit_macros.svh"
module rational_arith_unit #(
  parameter int unsigned OPERAND_WIDTH = rau_pkg::OperandWidthDef
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rau_pkg::OpWidth-1:0]      in_opcode,
  input  logic signed [OPERAND_WIDTH-1:0]  in_a_num,
  input  logic signed [OPERAND_WIDTH-1:0]  in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0]  in_b_num,
  input  logic signed [OPERAND_WIDTH-1:0]  in_b_den,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [2*OPERAND_WIDTH:0]  out_res_num,
  output logic [2*OPERAND_WIDTH-2:0]       out_res_den,
  output logic                             out_truth,
  output logic                             out_status
);
  rau_pkg::cmd_t cmd;
  rau_pkg::sts_t sts;

  rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk(clk), .cmd(cmd), .sts(sts), .in_opcode(in_opcode),
    .in_a_num(in_a_num), .in_a_den(in_a_den), .in_b_num(in_b_num), .in_b_den(in_b_den),
    .res_num(out_res_num), .res_den(out_res_den), .truth(out_truth), .status(out_status)
  );

  rau_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  `RAU_ASSERT_IMP(a_one_side, clk, rst_n, 1'b1, !(in_ready && out_valid))
  `RAU_ASSERT_IMP(a_den_pos, clk, rst_n, out_valid, out_res_den != '0)
  `RAU_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && out_status,
                  out_res_num == '0 && !out_truth)
  `RAU_ASSERT_NXT(a_take, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule
